// File: rtl/dltq_pkg.sv
// shared types and codes for the delta-list task timer queue
`timescale 1ns / 1ps

package dltq_pkg;

    // request kinds
    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;

    // one request item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_id;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
    } req_t;

    // one result item
    typedef struct packed {
        logic       ran_valid;
        logic [7:0] ran_task;
        logic       status;
    } rsp_t;

    // contents of one list slot
    typedef struct packed {
        logic        used;
        logic [7:0]  task_id;
        logic [31:0] delta;
        logic [31:0] period;
    } entry_t;

    // entry travelling down the chain during an insert
    typedef struct packed {
        logic        valid;
        logic        shift;
        logic [7:0]  task_id;
        logic [31:0] delta;
        logic [31:0] period;
    } tok_t;

    // commands to the cells: shift_down reaches every cell, tick only the head
    typedef struct packed {
        logic tick;
        logic shift_down;
    } cmd_t;

endpackage

// File: rtl/dltq_cell.sv
// one slot of the delta list, passing inserted entries to its right neighbor
`timescale 1ns / 1ps

module dltq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  dltq_pkg::cmd_t   cmd,
    input  dltq_pkg::entry_t nbr,
    input  dltq_pkg::tok_t   cin,
    output dltq_pkg::tok_t   cout,
    output dltq_pkg::entry_t ent,
    output logic             absorb
);

    dltq_pkg::entry_t ent_reg;
    dltq_pkg::entry_t ent_next;
    dltq_pkg::tok_t   tok_reg;
    dltq_pkg::tok_t   tok_next;

    // slot update: shift down, tick, or handle an incoming entry
    always_comb
    begin
        ent_next = ent_reg;
        tok_next = '0;
        absorb   = 1'b0;
        priority if (cmd.shift_down)
        begin
            ent_next = nbr;
        end
        else if (cmd.tick)
        begin
            if (ent_reg.used && ent_reg.delta != 32'd0)
                ent_next.delta = ent_reg.delta - 32'd1;
        end
        else if (cin.valid)
        begin
            priority if (!ent_reg.used)
            begin
                // first free slot takes the entry and ends the insert
                ent_next = '{used: 1'b1, task_id: cin.task_id, delta: cin.delta,
                             period: cin.period};
                absorb   = 1'b1;
            end
            else if (cin.shift)
            begin
                // shifting phase: swap with the carried entry
                ent_next = '{used: 1'b1, task_id: cin.task_id, delta: cin.delta,
                             period: cin.period};
                tok_next = '{valid: 1'b1, shift: 1'b1, task_id: ent_reg.task_id,
                             delta: ent_reg.delta, period: ent_reg.period};
            end
            else if (cin.delta >= ent_reg.delta)
            begin
                // new task goes later: pay this slot's delta and move on
                tok_next = '{valid: 1'b1, shift: 1'b0, task_id: cin.task_id,
                             delta: cin.delta - ent_reg.delta, period: cin.period};
            end
            else
            begin
                // new task lands here, old entry keeps the remainder
                ent_next = '{used: 1'b1, task_id: cin.task_id, delta: cin.delta,
                             period: cin.period};
                tok_next = '{valid: 1'b1, shift: 1'b1, task_id: ent_reg.task_id,
                             delta: ent_reg.delta - cin.delta, period: ent_reg.period};
            end
        end
    end

    // slot and outgoing entry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
            tok_reg <= tok_next;
        end
    end

    assign ent  = ent_reg;
    assign cout = tok_reg;

endmodule

// File: rtl/delta_list_task_timer_queue.sv
// top level of the delta-list task timer queue: control and the row of slots
`timescale 1ns / 1ps
//
// Usage: requests enter on req (valid/stall), one result per request leaves
// on rsp (valid/stall). A request is taken when req_valid is high and
// req_stall is low; req_stall is high while a request is in progress.
// Add requests insert a task into a chain of MAX_ENTRIES slots; the new
// entry walks one slot per cycle up to the first free slot. A full list
// answers an add with status set. A dispatch releases the ready head,
// shifts the list down and, for a periodic task, re-inserts it through
// the chain. The next request is taken on the cycle after the result is
// loaded into the output register. The result sits in an output register;
// a new request is taken while that result waits, and a later result waits
// in the control logic until the receiver drops rsp_stall. Reset empties
// every slot and clears the ready flag; no clearing pass is needed.

module delta_list_task_timer_queue #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dltq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dltq_pkg::rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t             state_reg;
    dltq_pkg::rsp_t     res_reg;
    dltq_pkg::rsp_t     rsp_reg;
    logic               rsp_valid_reg;
    logic               head_ready_reg;
    dltq_pkg::tok_t     inj_reg;

    dltq_pkg::entry_t   ent [MAX_ENTRIES];
    dltq_pkg::tok_t     tok [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] absorb_vec;
    logic [MAX_ENTRIES-1:0] tok_valid_vec;

    logic accept;
    logic tick_go;
    logic disp_go;
    logic full;
    logic head_place;
    logic rsp_load;

    // handshake and command decode
    assign req_stall  = (state_reg != S_IDLE);
    assign accept     = req_valid && !req_stall;
    assign tick_go    = accept && (req.kind == dltq_pkg::KIND_TICK);
    assign disp_go    = accept && (req.kind == dltq_pkg::KIND_DISPATCH)
                        && head_ready_reg && ent[0].used;
    assign full       = ent[MAX_ENTRIES-1].used;
    assign head_place = inj_reg.valid && (!ent[0].used || inj_reg.delta < ent[0].delta);
    assign rsp_load   = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // row of slots
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        dltq_pkg::cmd_t   cmd_k;
        dltq_pkg::entry_t nbr_k;
        dltq_pkg::tok_t   cin_k;

        assign cmd_k.tick       = tick_go && (k == 0);
        assign cmd_k.shift_down = disp_go;

        if (k == 0)
        begin : g_first
            assign cin_k = inj_reg;
        end
        else
        begin : g_rest
            assign cin_k = tok[k-1];
        end

        if (k == MAX_ENTRIES - 1)
        begin : g_last
            assign nbr_k = '0;
        end
        else
        begin : g_mid
            assign nbr_k = ent[k+1];
        end

        dltq_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd_k),
            .nbr    (nbr_k),
            .cin    (cin_k),
            .cout   (tok[k]),
            .ent    (ent[k]),
            .absorb (absorb_vec[k])
        );

        assign tok_valid_vec[k] = tok[k].valid;
    end

    // control state, ready flag, insert launch and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            head_ready_reg <= 1'b0;
            inj_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.kind)
                            dltq_pkg::KIND_ADD:
                            begin
                                if (full)
                                begin
                                    res_reg   <= '{ran_valid: 1'b0, ran_task: 8'd0,
                                                   status: 1'b1};
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    res_reg   <= '0;
                                    inj_reg   <= '{valid: 1'b1, shift: 1'b0,
                                                   task_id: req.task_id,
                                                   delta: req.delay_ticks,
                                                   period: req.period_ticks};
                                    state_reg <= S_WALK;
                                end
                            end
                            dltq_pkg::KIND_TICK:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                                if (ent[0].used && ent[0].delta == 32'd0)
                                    head_ready_reg <= 1'b1;
                            end
                            dltq_pkg::KIND_DISPATCH:
                            begin
                                if (disp_go)
                                begin
                                    res_reg        <= '{ran_valid: 1'b1,
                                                        ran_task: ent[0].task_id,
                                                        status: 1'b0};
                                    head_ready_reg <= 1'b0;
                                    if (ent[0].period != 32'd0)
                                    begin
                                        inj_reg   <= '{valid: 1'b1, shift: 1'b0,
                                                       task_id: ent[0].task_id,
                                                       delta: ent[0].period,
                                                       period: ent[0].period};
                                        state_reg <= S_WALK;
                                    end
                                    else
                                    begin
                                        state_reg <= S_DONE;
                                    end
                                end
                                else
                                begin
                                    res_reg   <= '0;
                                    state_reg <= S_DONE;
                                end
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    // launch lasts one cycle, the chain carries it from here
                    inj_reg.valid <= 1'b0;
                    if (head_place)
                        head_ready_reg <= 1'b0;
                    if (|absorb_vec)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // output register
            if (rsp_load)
            begin
                rsp_reg       <= res_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // only one slot can take the inserted entry in a cycle
    a_one_absorb: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(absorb_vec))
        else $error("more than one slot absorbed an entry");

    // an insert never runs off the end of the row
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !tok[MAX_ENTRIES-1].valid)
        else $error("entry carried past the last slot");

    // a ready head is always an occupied slot
    a_ready_used: assert property (@(posedge clk) disable iff (!rst_n)
        head_ready_reg |-> ent[0].used)
        else $error("head marked ready while empty");

    // no entry in flight once control is back to idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tok_valid_vec == '0 && !inj_reg.valid))
        else $error("insert still in flight while idle");

    // a release never reports a dropped add
    a_rsp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && res_reg.ran_valid) |-> !res_reg.status)
        else $error("release and full status together");

endmodule
